// ===== rtl/ptm_pkg.sv =====
// shared types and codes of the per-address traffic meter
package ptm_pkg;

  localparam logic [2:0] OP_PACKET = 3'd0;
  localparam logic [2:0] OP_TICK   = 3'd1;
  localparam logic [2:0] OP_QUERY  = 3'd2;
  localparam logic [2:0] OP_REMOVE = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [7:0] UDP_HDR_BYTES = 8'd8;
  localparam logic [7:0] BYTE_ALL_ONES = 8'hff;

  typedef struct packed {
    logic [31:0] up;
    logic [31:0] dn;
  } slot_t;

endpackage

// ===== rtl/ptm_ram.sv =====
// generic single-write, single-read ram with registered read data
module ptm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/per_address_traffic_meter_unit.sv =====
// per-address traffic meter: table scan, read-modify-write of entry and slot rams
//
//  channel | handshake                  | word
//  --------+----------------------------+------------------------------------------
//  in      | in_valid_i / in_ready_o    | op, addresses, header fields, key
//  out     | out_valid_o / out_ready_i  | flags, totals, rates, last active tick
//  cfg     | psel/penable/pwrite/pready | local_addr at 0x0, net_mask at 0x4
//
// one word at a time; a lookup walks the table, reading and comparing each valid entry
// and skipping free ones; packet: lookup per charged address, then a charge of the current
// slot (hit) or a write of every window slot (new entry); tick: each valid entry is advanced;
// query: lookup, slot reads, then a division of the idle-slot sum; every word ends in ST_DONE
// no clearing pass after reset: of the table, only the valid flops are cleared
// a finished word waits in the output register while the next word is taken
module per_address_traffic_meter_unit
  import ptm_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64,
  parameter int WINDOW_SLOTS  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  op_i,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] dst_addr_i,
  input  logic [7:0]  protocol_i,
  input  logic [15:0] total_length_i,
  input  logic [3:0]  ip_header_words_i,
  input  logic [3:0]  tcp_header_words_i,
  input  logic [31:0] key_addr_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        counted_up_o,
  output logic        counted_down_o,
  output logic        dropped_full_o,
  output logic        found_o,
  output logic [63:0] total_up_o,
  output logic [63:0] total_down_o,
  output logic [31:0] rate_up_o,
  output logic [31:0] rate_down_o,
  output logic [31:0] last_active_tick_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW     = $clog2(TABLE_ENTRIES + 1);
  localparam int PW     = $clog2(WINDOW_SLOTS);
  localparam int SD     = TABLE_ENTRIES * WINDOW_SLOTS;
  localparam int SAW    = $clog2(SD);
  localparam int SUMW   = 32 + PW;
  localparam int DIGITS = (SUMW + 7) / 8;
  localparam int QW     = 8 * DIGITS;
  localparam int VW     = PW + 8;
  localparam int RS     = 24;
  localparam int DCW    = $clog2(DIGITS + 1);

  localparam logic [CW-1:0]   IDX_END  = CW'(TABLE_ENTRIES);
  localparam logic [PW-1:0]   PTR_LAST = PW'(WINDOW_SLOTS - 1);
  localparam logic [PW:0]     DIVISOR  = (PW + 1)'(WINDOW_SLOTS - 1);
  localparam logic [RS:0]     RECIP    =
    (RS + 1)'(((1 << RS) + WINDOW_SLOTS - 2) / (WINDOW_SLOTS - 1));
  localparam logic [DCW-1:0]  DIV_STEPS = DCW'(DIGITS);

  typedef struct packed {
    logic [31:0]   addr;
    logic [63:0]   sum_up;
    logic [63:0]   sum_dn;
    logic [31:0]   last;
    logic [PW-1:0] ptr;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN_RD, ST_SCAN_CMP, ST_CHARGE, ST_ALLOC, ST_NEXT,
    ST_TICK_RD, ST_TICK_WR, ST_SUM_RD, ST_SUM_ACC, ST_DIV, ST_DONE
  } state_e;

  state_e state_q;

  logic [31:0] local_addr_q, net_mask_q, tick_q;
  logic [TABLE_ENTRIES-1:0] valid_q;

  logic [2:0]   op_q;
  logic [15:0]  len_q;
  logic         dst_ok_q, up_q;
  logic [31:0]  key_q, dst_q;
  logic [CW-1:0] idx_q;
  logic [IW-1:0] ent_q, free_q;
  logic         free_vld_q;
  entry_t       entry_q;
  logic [PW-1:0] k_q;
  logic         cnt_up_q, cnt_dn_q, full_q, found_q;
  logic [QW-1:0]   qu_q, qd_q;
  logic [PW-1:0]   ru_q, rd_q;
  logic [DCW-1:0]  dcnt_q;

  logic        out_valid_q;
  logic        o_up_q, o_dn_q, o_full_q, o_found_q;
  logic [63:0] o_tot_up_q, o_tot_dn_q;
  logic [31:0] o_rate_up_q, o_rate_dn_q, o_last_q;

  // rams
  logic          e_we, e_re;
  logic [IW-1:0] e_waddr, e_raddr;
  entry_t        e_wdata, e_rdata;
  logic          s_we, s_re;
  logic [SAW-1:0] s_waddr, s_raddr;
  slot_t         s_wdata, s_rdata;

  ptm_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_ENTRIES)) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (e_we),
    .waddr_i(e_waddr),
    .wdata_i(e_wdata),
    .re_i   (e_re),
    .raddr_i(e_raddr),
    .rdata_o(e_rdata)
  );

  ptm_ram #(.WIDTH($bits(slot_t)), .DEPTH(SD)) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (s_we),
    .waddr_i(s_waddr),
    .wdata_i(s_wdata),
    .re_i   (s_re),
    .raddr_i(s_raddr),
    .rdata_o(s_rdata)
  );

  function automatic logic addr_ok(input logic [31:0] a);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (a[8*i +: 8] == 8'h00 || a[8*i +: 8] == BYTE_ALL_ONES) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  function automatic logic [SAW-1:0] slot_addr(input logic [IW-1:0] e, input logic [PW-1:0] p);
    return SAW'(e) * SAW'(WINDOW_SLOTS) + SAW'(p);
  endfunction

  // header length and payload
  logic [7:0]  hdr_len;
  logic [15:0] pay_len;
  logic        is_tcp, is_udp, src_ok, dst_ok;

  always_comb begin
    is_tcp  = protocol_i == PROTO_TCP;
    is_udp  = protocol_i == PROTO_UDP;
    hdr_len = {2'b00, ip_header_words_i, 2'b00}
            + (is_tcp ? {2'b00, tcp_header_words_i, 2'b00} : UDP_HDR_BYTES);
    pay_len = (total_length_i > {8'h00, hdr_len}) ? total_length_i - {8'h00, hdr_len} : 16'd0;
    src_ok  = ((src_addr_i & net_mask_q) == (local_addr_q & net_mask_q)) && addr_ok(src_addr_i);
    dst_ok  = ((dst_addr_i & net_mask_q) == (local_addr_q & net_mask_q)) && addr_ok(dst_addr_i);
  end

  logic          idx_end, idx_valid, hit;
  logic [IW-1:0] idx;
  logic [PW-1:0] tick_ptr;
  slot_t         new_slot;
  entry_t        new_entry, upd_entry;
  logic [VW-1:0] vu, vd, mu, md;
  logic [VW+RS:0] pu, pd;
  logic [7:0]    gu, gd;

  always_comb begin
    idx       = idx_q[IW-1:0];
    idx_end   = idx_q == IDX_END;
    idx_valid = !idx_end && valid_q[idx];
    hit       = e_rdata.addr == key_q;
    tick_ptr  = (e_rdata.ptr == PTR_LAST) ? '0 : e_rdata.ptr + 1'b1;

    new_slot.up = up_q ? {16'h0000, len_q} : 32'd0;
    new_slot.dn = up_q ? 32'd0 : {16'h0000, len_q};

    new_entry        = '0;
    new_entry.addr   = key_q;
    new_entry.sum_up = {32'd0, new_slot.up};
    new_entry.sum_dn = {32'd0, new_slot.dn};
    new_entry.last   = tick_q;

    upd_entry        = entry_q;
    upd_entry.sum_up = entry_q.sum_up + {32'd0, new_slot.up};
    upd_entry.sum_dn = entry_q.sum_dn + {32'd0, new_slot.dn};
    upd_entry.last   = tick_q;

    // next quotient byte: remainder and top byte, times the reciprocal of the divisor
    vu = {ru_q, qu_q[QW-1 -: 8]};
    vd = {rd_q, qd_q[QW-1 -: 8]};
    pu = (VW + RS + 1)'(vu) * (VW + RS + 1)'(RECIP);
    pd = (VW + RS + 1)'(vd) * (VW + RS + 1)'(RECIP);
    gu = pu[RS +: 8];
    gd = pd[RS +: 8];
    mu = VW'(gu) * VW'(DIVISOR);
    md = VW'(gd) * VW'(DIVISOR);

    e_we    = 1'b0;
    e_waddr = ent_q;
    e_wdata = upd_entry;
    e_re    = 1'b0;
    e_raddr = idx;
    s_we    = 1'b0;
    s_waddr = slot_addr(ent_q, entry_q.ptr);
    s_wdata = '0;
    s_re    = 1'b0;
    s_raddr = slot_addr(idx, e_rdata.ptr);

    unique case (state_q)
      ST_SCAN_RD, ST_TICK_RD: begin
        e_re = idx_valid;
      end
      ST_SCAN_CMP: begin
        s_re = hit && op_q == OP_PACKET;
      end
      ST_CHARGE: begin
        e_we       = 1'b1;
        s_we       = 1'b1;
        s_wdata.up = s_rdata.up + new_slot.up;
        s_wdata.dn = s_rdata.dn + new_slot.dn;
      end
      ST_ALLOC: begin
        s_we    = 1'b1;
        s_waddr = slot_addr(ent_q, k_q);
        s_wdata = (k_q == '0) ? new_slot : '0;
        e_we    = k_q == PTR_LAST;
        e_wdata = new_entry;
      end
      ST_TICK_WR: begin
        e_we        = 1'b1;
        e_waddr     = idx;
        e_wdata     = e_rdata;
        e_wdata.ptr = tick_ptr;
        s_we        = 1'b1;
        s_waddr     = slot_addr(idx, tick_ptr);
      end
      ST_SUM_RD: begin
        s_re    = 1'b1;
        s_raddr = slot_addr(ent_q, k_q);
      end
      default: begin
      end
    endcase
  end

  assign in_ready_o = state_q == ST_IDLE;
  assign pready     = 1'b1;
  assign prdata     = paddr[2] ? net_mask_q : local_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      local_addr_q <= '0;
      net_mask_q   <= '0;
      tick_q       <= '0;
      valid_q      <= '0;
      out_valid_q  <= 1'b0;
      free_vld_q   <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        if (paddr[2]) begin
          net_mask_q <= pwdata;
        end else begin
          local_addr_q <= pwdata;
        end
      end
      if (out_valid_q && out_ready_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            op_q       <= op_i;
            len_q      <= pay_len;
            dst_ok_q   <= dst_ok;
            dst_q      <= dst_addr_i;
            idx_q      <= '0;
            free_vld_q <= 1'b0;
            cnt_up_q   <= 1'b0;
            cnt_dn_q   <= 1'b0;
            full_q     <= 1'b0;
            found_q    <= 1'b0;
            unique case (op_i)
              OP_PACKET: begin
                if ((is_tcp || is_udp) && src_ok) begin
                  key_q   <= src_addr_i;
                  up_q    <= 1'b1;
                  state_q <= ST_SCAN_RD;
                end else if ((is_tcp || is_udp) && dst_ok) begin
                  key_q   <= dst_addr_i;
                  up_q    <= 1'b0;
                  state_q <= ST_SCAN_RD;
                end else begin
                  state_q <= ST_DONE;
                end
              end
              OP_TICK: begin
                tick_q  <= tick_q + 32'd1;
                state_q <= ST_TICK_RD;
              end
              OP_QUERY, OP_REMOVE: begin
                key_q   <= key_addr_i;
                state_q <= ST_SCAN_RD;
              end
              OP_CLEAR: begin
                valid_q <= '0;
                state_q <= ST_DONE;
              end
              default: begin
                state_q <= ST_DONE;
              end
            endcase
          end
        end
        ST_SCAN_RD: begin
          if (idx_end) begin
            // no match in the table
            if (op_q == OP_PACKET) begin
              if (free_vld_q) begin
                ent_q   <= free_q;
                k_q     <= '0;
                state_q <= ST_ALLOC;
              end else begin
                full_q  <= 1'b1;
                state_q <= ST_NEXT;
              end
            end else begin
              state_q <= ST_DONE;
            end
          end else if (idx_valid) begin
            state_q <= ST_SCAN_CMP;
          end else begin
            if (!free_vld_q) begin
              free_q     <= idx;
              free_vld_q <= 1'b1;
            end
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_SCAN_CMP: begin
          if (hit) begin
            ent_q   <= idx;
            entry_q <= e_rdata;
            unique case (op_q)
              OP_PACKET: state_q <= ST_CHARGE;
              OP_QUERY: begin
                found_q <= 1'b1;
                k_q     <= '0;
                qu_q    <= '0;
                qd_q    <= '0;
                state_q <= ST_SUM_RD;
              end
              default: begin
                found_q      <= 1'b1;
                valid_q[idx] <= 1'b0;
                state_q      <= ST_DONE;
              end
            endcase
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= ST_SCAN_RD;
          end
        end
        ST_CHARGE: begin
          if (up_q) begin
            cnt_up_q <= 1'b1;
          end else begin
            cnt_dn_q <= 1'b1;
          end
          state_q <= ST_NEXT;
        end
        ST_ALLOC: begin
          // fresh entry: zero every slot, charge slot 0
          if (k_q == PTR_LAST) begin
            valid_q[ent_q] <= 1'b1;
            if (up_q) begin
              cnt_up_q <= 1'b1;
            end else begin
              cnt_dn_q <= 1'b1;
            end
            state_q <= ST_NEXT;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        ST_NEXT: begin
          if (up_q && dst_ok_q) begin
            key_q      <= dst_q;
            up_q       <= 1'b0;
            idx_q      <= '0;
            free_vld_q <= 1'b0;
            state_q    <= ST_SCAN_RD;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_TICK_RD: begin
          if (idx_end) begin
            state_q <= ST_DONE;
          end else if (idx_valid) begin
            state_q <= ST_TICK_WR;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_TICK_WR: begin
          idx_q   <= idx_q + 1'b1;
          state_q <= ST_TICK_RD;
        end
        ST_SUM_RD: begin
          state_q <= ST_SUM_ACC;
        end
        ST_SUM_ACC: begin
          if (k_q != entry_q.ptr) begin
            qu_q <= qu_q + QW'(s_rdata.up);
            qd_q <= qd_q + QW'(s_rdata.dn);
          end
          if (k_q == PTR_LAST) begin
            ru_q    <= '0;
            rd_q    <= '0;
            dcnt_q  <= '0;
            state_q <= ST_DIV;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= ST_SUM_RD;
          end
        end
        ST_DIV: begin
          // long division by the idle slot count, one quotient byte a cycle
          if (dcnt_q == DIV_STEPS) begin
            state_q <= ST_DONE;
          end else begin
            dcnt_q <= dcnt_q + 1'b1;
            ru_q   <= PW'(vu - mu);
            rd_q   <= PW'(vd - md);
            qu_q   <= {qu_q[QW-9:0], gu};
            qd_q   <= {qd_q[QW-9:0], gd};
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            o_up_q      <= cnt_up_q;
            o_dn_q      <= cnt_dn_q;
            o_full_q    <= full_q;
            o_found_q   <= found_q;
            if (found_q && op_q == OP_QUERY) begin
              o_tot_up_q  <= entry_q.sum_up;
              o_tot_dn_q  <= entry_q.sum_dn;
              o_rate_up_q <= qu_q[31:0];
              o_rate_dn_q <= qd_q[31:0];
              o_last_q    <= entry_q.last;
            end else begin
              o_tot_up_q  <= '0;
              o_tot_dn_q  <= '0;
              o_rate_up_q <= '0;
              o_rate_dn_q <= '0;
              o_last_q    <= '0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign counted_up_o       = o_up_q;
  assign counted_down_o     = o_dn_q;
  assign dropped_full_o     = o_full_q;
  assign found_o            = o_found_q;
  assign total_up_o         = o_tot_up_q;
  assign total_down_o       = o_tot_dn_q;
  assign rate_up_o          = o_rate_up_q;
  assign rate_down_o        = o_rate_dn_q;
  assign last_active_tick_o = o_last_q;

endmodule

// ===== rtl/ptm_checker.sv =====
// port-level checks of the traffic meter and their binding
module ptm_checker
  import ptm_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        counted_up_o,
  input logic        counted_down_o,
  input logic        dropped_full_o,
  input logic        found_o,
  input logic [63:0] total_up_o,
  input logic [63:0] total_down_o,
  input logic [31:0] rate_up_o,
  input logic [31:0] last_active_tick_o,
  input logic        pready
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(total_up_o) && $stable(found_o))
    else $error("result word changed while stalled");

  // lookup results and packet charges never share a word
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> !counted_up_o && !counted_down_o && !dropped_full_o)
    else $error("found mixed with packet flags");

  // nothing reported for an absent address
  a_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> total_up_o == 64'd0 && total_down_o == 64'd0
                             && rate_up_o == 32'd0 && last_active_tick_o == 32'd0)
    else $error("query data without a hit");

  // a full table leaves at least one side uncharged
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dropped_full_o |-> !(counted_up_o && counted_down_o))
    else $error("drop flagged with both sides charged");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind per_address_traffic_meter_unit ptm_checker u_ptm_checker (.*);

// ===== verif/tb_per_address_traffic_meter_unit.sv =====
// testbench of the per-address traffic meter: predicted results checked word by word
`timescale 1ns / 1ps

module tb_per_address_traffic_meter_unit;
  import ptm_pkg::*;

  localparam int NENT = 64;
  localparam int NSLOT = 8;
  localparam int STALL_LIMIT = 20000;
  localparam logic [2:0] REG_LOCAL_ADDR = 3'd0;
  localparam logic [2:0] REG_NET_MASK = 3'd4;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  proto;
    logic [15:0] tot;
    logic [3:0]  ihl;
    logic [3:0]  doff;
    logic [31:0] key;
  } pkt_word_t;

  typedef struct packed {
    logic        up;
    logic        dn;
    logic        full;
    logic        found;
    logic [63:0] tot_up;
    logic [63:0] tot_dn;
    logic [31:0] rate_up;
    logic [31:0] rate_dn;
    logic [31:0] last;
  } meter_word_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic [2:0] op_i;
  logic [31:0] src_addr_i, dst_addr_i, key_addr_i;
  logic [7:0] protocol_i;
  logic [15:0] total_length_i;
  logic [3:0] ip_header_words_i, tcp_header_words_i;
  logic counted_up_o, counted_down_o, dropped_full_o, found_o;
  logic [63:0] total_up_o, total_down_o;
  logic [31:0] rate_up_o, rate_down_o, last_active_tick_o;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  per_address_traffic_meter_unit u_dut (.*);

  // predictor state
  logic [31:0] m_local, m_mask, m_ticks;
  logic        e_valid [NENT];
  logic [31:0] e_addr [NENT];
  logic [63:0] e_sum_up [NENT], e_sum_dn [NENT];
  logic [31:0] e_slot_up [NENT][NSLOT], e_slot_dn [NENT][NSLOT];
  logic [2:0]  e_ptr [NENT];
  logic [31:0] e_last [NENT];

  meter_word_t expected_words[$];
  int errors = 0;
  bit quiet = 0;
  int idle_pct = 29;
  int stall_cnt = 0;

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic bit addr_ok(logic [31:0] a);
    for (int i = 0; i < 4; i++)
      if (a[8*i +: 8] == 8'h00 || a[8*i +: 8] == BYTE_ALL_ONES) return 0;
    return 1;
  endfunction

  function automatic bit local_host(logic [31:0] a);
    return ((a & m_mask) == (m_local & m_mask)) && addr_ok(a);
  endfunction

  function automatic int lookup(logic [31:0] a);
    for (int i = 0; i < NENT; i++)
      if (e_valid[i] && e_addr[i] == a) return i;
    return -1;
  endfunction

  function automatic bit charge(logic [31:0] a, logic [31:0] len, bit up, ref bit full);
    int e;
    e = lookup(a);
    if (e < 0) begin
      e = 0;
      while (e < NENT && e_valid[e]) e++;
      if (e >= NENT) begin
        full = 1;
        return 0;
      end
      e_valid[e] = 1;
      e_addr[e] = a;
      e_sum_up[e] = 0;
      e_sum_dn[e] = 0;
      for (int j = 0; j < NSLOT; j++) begin
        e_slot_up[e][j] = 0;
        e_slot_dn[e][j] = 0;
      end
      e_ptr[e] = 0;
    end
    if (up) begin
      e_sum_up[e] += len;
      e_slot_up[e][e_ptr[e]] += len;
    end else begin
      e_sum_dn[e] += len;
      e_slot_dn[e][e_ptr[e]] += len;
    end
    e_last[e] = m_ticks;
    return 1;
  endfunction

  function automatic meter_word_t meter_predict(pkt_word_t w);
    meter_word_t r;
    logic [31:0] hdr, len;
    logic [63:0] su, sd;
    bit full;
    int e;
    r = '0;
    full = 0;
    case (w.op)
      OP_PACKET: begin
        if (w.proto == PROTO_TCP || w.proto == PROTO_UDP) begin
          hdr = 4 * w.ihl + ((w.proto == PROTO_TCP) ? 4 * w.doff : UDP_HDR_BYTES);
          len = (w.tot > hdr) ? w.tot - hdr : 0;
          if (local_host(w.src) && charge(w.src, len, 1, full)) r.up = 1;
          if (local_host(w.dst) && charge(w.dst, len, 0, full)) r.dn = 1;
          r.full = full;
        end
      end
      OP_TICK: begin
        m_ticks++;
        for (int i = 0; i < NENT; i++)
          if (e_valid[i]) begin
            e_ptr[i]++;
            e_slot_up[i][e_ptr[i]] = 0;
            e_slot_dn[i][e_ptr[i]] = 0;
          end
      end
      OP_QUERY: begin
        e = lookup(w.key);
        if (e >= 0) begin
          su = 0;
          sd = 0;
          for (int j = 0; j < NSLOT; j++)
            if (j != e_ptr[e]) begin
              su += e_slot_up[e][j];
              sd += e_slot_dn[e][j];
            end
          r.found = 1;
          r.tot_up = e_sum_up[e];
          r.tot_dn = e_sum_dn[e];
          r.rate_up = 32'(su / (NSLOT - 1));
          r.rate_dn = 32'(sd / (NSLOT - 1));
          r.last = e_last[e];
        end
      end
      OP_REMOVE: begin
        e = lookup(w.key);
        if (e >= 0) begin
          e_valid[e] = 0;
          r.found = 1;
        end
      end
      OP_CLEAR: for (int i = 0; i < NENT; i++) e_valid[i] = 0;
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_word(pkt_word_t w);
    while (!quiet && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    op_i <= w.op;
    src_addr_i <= w.src;
    dst_addr_i <= w.dst;
    protocol_i <= w.proto;
    total_length_i <= w.tot;
    ip_header_words_i <= w.ihl;
    tcp_header_words_i <= w.doff;
    key_addr_i <= w.key;
    do @(posedge clk_i); while (!in_ready_o);
    expected_words.push_back(meter_predict(w));
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= addr;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (addr == REG_LOCAL_ADDR) m_local = val; else m_mask = val;
  endtask

  task automatic drain;
    in_valid_i <= 0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_subnet(logic [31:0] net, logic [31:0] mask);
    drain();
    reg_write(REG_LOCAL_ADDR, net);
    reg_write(REG_NET_MASK, mask);
  endtask

  // addresses drawn from a small local pool so entries get reused
  function automatic logic [31:0] pick_addr();
    logic [31:0] a;
    int k;
    k = $urandom_range(99);
    if (k < 8) return $urandom();
    a = (m_local & m_mask) | (($urandom() << 8) & ~m_mask);
    a[7:0] = 8'(1 + $urandom_range(k < 90 ? 11 : 250));
    return a;
  endfunction

  function automatic pkt_word_t rand_word();
    pkt_word_t w;
    int k;
    w.src = pick_addr();
    w.dst = pick_addr();
    w.key = ($urandom_range(3) == 0) ? $urandom() : (($urandom_range(1) == 0) ? w.src : w.dst);
    w.tot = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(1500));
    w.ihl = 4'($urandom());
    w.doff = 4'($urandom());
    k = $urandom_range(9);
    w.proto = (k < 4) ? PROTO_TCP : (k < 8) ? PROTO_UDP : 8'($urandom());
    k = $urandom_range(99);
    w.op = (k < 62) ? OP_PACKET : (k < 72) ? OP_TICK : (k < 90) ? OP_QUERY :
           (k < 96) ? OP_REMOVE : (k < 97) ? OP_CLEAR : 3'($urandom());
    return w;
  endfunction

  task automatic test_directed;
    pkt_word_t w;
    set_subnet(32'h0a0b0000, 32'hffff0000);
    w = '{OP_PACKET, 32'h0a0b0101, 32'h0a0b0202, PROTO_TCP, 16'd1000, 4'd5, 4'd5, 32'd0};
    send_word(w);
    w.proto = PROTO_UDP;
    send_word(w);
    w.tot = 16'hffff; w.ihl = 4'hf; w.doff = 4'hf;
    send_word(w);
    w.proto = PROTO_TCP; w.tot = 16'd10;
    send_word(w);
    w.proto = 8'hff;
    send_word(w);
    w = '{OP_PACKET, 32'h0a0b0303, 32'h0a0b0303, PROTO_UDP, 16'd300, 4'd5, 4'd0, 32'd0};
    send_word(w);
    w.src = 32'h0a0b00ff; w.dst = 32'h0a0bff05;
    send_word(w);
    w.src = 32'hffffffff; w.dst = 32'h00000000;
    send_word(w);
    w = '{OP_TICK, '1, '1, '1, '1, '1, '1, '1};
    send_word(w);
    w = '{OP_QUERY, 32'd0, 32'd0, 8'd0, 16'd0, 4'd0, 4'd0, 32'h0a0b0101};
    send_word(w);
    w.key = 32'h0a0b0303;
    send_word(w);
    w.key = 32'h12345678;
    send_word(w);
    w.op = OP_REMOVE; w.key = 32'h0a0b0101;
    send_word(w);
    send_word(w);
    w.op = OP_CLEAR;
    send_word(w);
    w.op = OP_QUERY; w.key = 32'h0a0b0202;
    send_word(w);
    for (int op = 5; op < 8; op++) begin
      w.op = 3'(op);
      send_word(w);
    end
  endtask

  task automatic test_table_full;
    pkt_word_t w;
    set_subnet(32'h0a000000, 32'hff000000);
    w = '{OP_PACKET, 32'h0a0a0a01, 32'h0a0a0b01, PROTO_UDP, 16'd100, 4'd5, 4'd0, 32'd0};
    for (int i = 0; i < 34; i++) begin
      w.src[7:0] = 8'(i + 1);
      w.dst[7:0] = 8'(i + 1);
      send_word(w);
    end
    w.op = OP_QUERY; w.key = 32'h0a0a0a01;
    send_word(w);
    w.op = OP_CLEAR;
    send_word(w);
  endtask

  task automatic test_random(int n, logic [31:0] net, logic [31:0] mask);
    set_subnet(net, mask);
    for (int i = 0; i < n; i++) send_word(rand_word());
  endtask

  initial begin
    rst_ni = 0;
    in_valid_i = 0;
    out_ready_i = 0;
    op_i = 0; src_addr_i = 0; dst_addr_i = 0; protocol_i = 0;
    total_length_i = 0; ip_header_words_i = 0; tcp_header_words_i = 0; key_addr_i = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    m_local = 0; m_mask = 0; m_ticks = 0;
    for (int i = 0; i < NENT; i++) e_valid[i] = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    test_directed();
    test_table_full();
    test_random(200, 32'hc0a80000, 32'hffff0000);
    quiet = 1;
    test_random(120, 32'h0a000000, 32'hff000000);
    quiet = 0;
    test_random(100, 32'hac100000, 32'hfff00000);
    test_random(60, 32'hffffffff, 32'hffffffff);
    test_random(60, 32'h0, 32'h0);
    test_random(60, 32'h0a0b0c00, 32'hffffff00);
    drain();
    if (errors == 0) $display("tb_per_address_traffic_meter_unit: clean");
    else $display("tb_per_address_traffic_meter_unit: errors");
    $finish;
  end

  always @(posedge clk_i) begin
    out_ready_i <= quiet || ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk_i) begin
    meter_word_t x;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        x = expected_words.pop_front();
        if (counted_up_o !== x.up) begin
          $error("counted_up exp %0h got %0h", x.up, counted_up_o); errors++;
        end
        if (counted_down_o !== x.dn) begin
          $error("counted_down exp %0h got %0h", x.dn, counted_down_o); errors++;
        end
        if (dropped_full_o !== x.full) begin
          $error("dropped_full exp %0h got %0h", x.full, dropped_full_o); errors++;
        end
        if (found_o !== x.found) begin
          $error("found exp %0h got %0h", x.found, found_o); errors++;
        end
        if (total_up_o !== x.tot_up) begin
          $error("total_up exp %0h got %0h", x.tot_up, total_up_o); errors++;
        end
        if (total_down_o !== x.tot_dn) begin
          $error("total_down exp %0h got %0h", x.tot_dn, total_down_o); errors++;
        end
        if (rate_up_o !== x.rate_up) begin
          $error("rate_up exp %0h got %0h", x.rate_up, rate_up_o); errors++;
        end
        if (rate_down_o !== x.rate_dn) begin
          $error("rate_down exp %0h got %0h", x.rate_dn, rate_down_o); errors++;
        end
        if (last_active_tick_o !== x.last) begin
          $error("last_active_tick exp %0h got %0h", x.last, last_active_tick_o); errors++;
        end
      end
    end
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel ||
        (expected_words.size() == 0 && !in_valid_i))
      stall_cnt <= 0;
    else if (stall_cnt >= STALL_LIMIT) begin
      $display("tb_per_address_traffic_meter_unit: errors");
      $finish;
    end else
      stall_cnt <= stall_cnt + 1;
  end

endmodule
